FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the active-low reset is low.
`define BCC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define BCC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/bcc_pkg.sv
// ----------------------------------------------------------------------------
// bcc_pkg
// Types and constants shared by the button click classifier modules.
// ----------------------------------------------------------------------------
package bcc_pkg;

    localparam int NUM_BUTTONS = 8;
    localparam int CNT_W       = 16;
    localparam int THR_W       = 16;
    localparam int CMP_W       = (CNT_W > THR_W) ? CNT_W : THR_W;
    localparam int PTR_W       = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int LEVEL_W     = 8;
    localparam int INDEX_W     = 3;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    localparam logic [THR_W-1:0]  THR_RESET    = THR_W'(100);
    localparam logic [APB_AW-1:0] ADDR_HOLD_THR = APB_AW'(0);

    // Per-button classification phases.
    typedef enum logic [5:0] {
        PH_IDLE        = 6'b000001,
        PH_FIRST_HIGH  = 6'b000010,
        PH_REP_SINGLE  = 6'b000100,
        PH_FIRST_LOW   = 6'b001000,
        PH_SECOND_HIGH = 6'b010000,
        PH_REP_DOUBLE  = 6'b100000
    } t_phase;

    // One event decision from the phase engine.
    typedef struct packed {
        logic               emit;
        logic               dbl;
        logic [INDEX_W-1:0] index;
    } t_event;

endpackage

FILE: src/bcc_cfg_regs.sv
// ----------------------------------------------------------------------------
// bcc_cfg_regs
// APB register file holding the hold threshold.
// ----------------------------------------------------------------------------
module bcc_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bcc_pkg::APB_AW-1:0]  paddr,
    input  logic [bcc_pkg::APB_DW-1:0]  pwdata,
    output logic [bcc_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output logic [bcc_pkg::THR_W-1:0]   o_hold_thr
);
    import bcc_pkg::*;

    logic [THR_W-1:0] r_hold_thr;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_thr <= THR_RESET;
        end else if (wr_en && (paddr == ADDR_HOLD_THR)) begin
            r_hold_thr <= pwdata[THR_W-1:0];
        end
    end

    always_comb begin
        unique case (paddr)
            ADDR_HOLD_THR: prdata = APB_DW'(r_hold_thr);
            default:       prdata = '0;
        endcase
    end

    assign o_hold_thr = r_hold_thr;

endmodule

FILE: src/bcc_phase_engine.sv
// ----------------------------------------------------------------------------
// bcc_phase_engine
// Per-button phase and counter store with the round-robin classification step.
// ----------------------------------------------------------------------------
module bcc_phase_engine (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  logic [bcc_pkg::LEVEL_W-1:0]  i_levels,
    input  logic [bcc_pkg::THR_W-1:0]    i_hold_thr,
    output bcc_pkg::t_event              o_event
);
    import bcc_pkg::*;

    t_phase           r_phase [NUM_BUTTONS];
    logic [CNT_W-1:0] r_cnt   [NUM_BUTTONS];
    logic [PTR_W-1:0] r_ptr;

    t_phase           cur_ph;
    t_phase           n_ph;
    logic [CNT_W-1:0] cur_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [PTR_W-1:0] n_ptr;
    logic [CMP_W-1:0] limit;
    logic             reached;
    logic             pressed;

    assign cur_ph  = r_phase[r_ptr];
    assign cur_cnt = r_cnt[r_ptr];
    // Buttons are active low on the wire.
    assign pressed = ~i_levels[r_ptr];

    // The threshold saturates at the counter's largest value.
    assign limit   = (CMP_W'(i_hold_thr) < CMP_W'({CNT_W{1'b1}})) ?
                     CMP_W'(i_hold_thr) : CMP_W'({CNT_W{1'b1}});
    assign reached = CMP_W'(cur_cnt) >= limit;

    assign n_ptr = (r_ptr == PTR_W'(NUM_BUTTONS - 1)) ? '0 : r_ptr + 1'b1;

    always_comb begin
        n_ph          = cur_ph;
        n_cnt         = cur_cnt;
        o_event.emit  = 1'b0;
        o_event.dbl   = 1'b0;
        o_event.index = INDEX_W'(r_ptr);
        unique case (cur_ph)
            PH_FIRST_HIGH: begin
                if (!pressed) begin
                    n_ph  = PH_FIRST_LOW;
                    n_cnt = '0;
                end else if (reached) begin
                    n_ph  = PH_REP_SINGLE;
                    n_cnt = '0;
                end else begin
                    n_cnt = cur_cnt + 1'b1;
                end
            end
            PH_REP_SINGLE: begin
                if (pressed) begin
                    o_event.emit = 1'b1;
                end else begin
                    n_ph  = PH_IDLE;
                    n_cnt = '0;
                end
            end
            PH_FIRST_LOW: begin
                if (pressed) begin
                    n_ph  = PH_SECOND_HIGH;
                    n_cnt = '0;
                end else if (reached) begin
                    o_event.emit = 1'b1;
                    n_ph         = PH_IDLE;
                    n_cnt        = '0;
                end else begin
                    n_cnt = cur_cnt + 1'b1;
                end
            end
            PH_SECOND_HIGH: begin
                if (!pressed) begin
                    o_event.emit = 1'b1;
                    o_event.dbl  = 1'b1;
                    n_ph         = PH_IDLE;
                    n_cnt        = '0;
                end else if (reached) begin
                    n_ph  = PH_REP_DOUBLE;
                    n_cnt = '0;
                end else begin
                    n_cnt = cur_cnt + 1'b1;
                end
            end
            PH_REP_DOUBLE: begin
                if (pressed) begin
                    o_event.emit = 1'b1;
                    o_event.dbl  = 1'b1;
                end else begin
                    n_ph  = PH_IDLE;
                    n_cnt = '0;
                end
            end
            default: begin
                // Idle: a press starts a fresh count, otherwise nothing changes.
                if (pressed) begin
                    n_ph  = PH_FIRST_HIGH;
                    n_cnt = '0;
                end else begin
                    n_ph = PH_IDLE;
                end
            end
        endcase
    end

    // Phases reset to idle; counters are always cleared on entry to a counting phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
            for (int k = 0; k < NUM_BUTTONS; k++) begin
                r_phase[k] <= PH_IDLE;
            end
        end else if (i_step) begin
            r_ptr          <= n_ptr;
            r_phase[r_ptr] <= n_ph;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_cnt[r_ptr] <= n_cnt;
        end
    end

endmodule

FILE: src/button_click_classifier_unit.sv
// ----------------------------------------------------------------------------
// button_click_classifier_unit
// Classifies single clicks, double clicks and long presses of up to eight
// active-low buttons, one button per scan item.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_axis    in         tdata[7:0] raw_levels (active-low button byte)
//  m_axis    out        tdata[2:0] button_index, tuser[0] double_click
//  APB       in/out     register 0 at byte address 0: hold_threshold[15:0]
//
//  Every scan item waits in the input register while the phase engine works
//  on it, and any event it yields is loaded into the result register when the
//  engine steps on that item. The engine's single state update per cycle sets
//  the rate: one item a cycle while the output is not held.
//  A held output stalls the engine; the input register still takes one item.
//  Reset is synchronous and active low; all buttons return to idle.
// ----------------------------------------------------------------------------
module button_click_classifier_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // APB configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bcc_pkg::APB_AW-1:0]   paddr,
    input  logic [bcc_pkg::APB_DW-1:0]   pwdata,
    output logic [bcc_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    // Scan items in
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,  // [7:0] raw_levels
    // Click events out
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [7:0]                   m_axis_tdata,  // [2:0] button_index, [7:3] zero
    output logic [0:0]                   m_axis_tuser   // [0] double_click
);
    import bcc_pkg::*;

    logic               r_in_valid;
    logic [LEVEL_W-1:0] r_in_levels;
    logic               r_out_valid;
    logic [INDEX_W-1:0] r_out_index;
    logic               r_out_dbl;
    logic [THR_W-1:0]   hold_thr;
    logic               out_free;
    logic               advance;
    t_event             ev;

    bcc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_hold_thr (hold_thr)
    );

    // The output register can take a new result when it is empty or being drained.
    assign out_free      = !r_out_valid || m_axis_tready;
    // The engine handles the registered item as soon as its result has a place.
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_levels <= s_axis_tdata;
        end
    end

    bcc_phase_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (advance),
        .i_levels   (r_in_levels),
        .i_hold_thr (hold_thr),
        .o_event    (ev)
    );

    // Result register: valid follows the event flag on each step; the payload loads only on an event.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= ev.emit;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && ev.emit) begin
            r_out_index <= ev.index;
            r_out_dbl   <= ev.dbl;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = 8'(r_out_index);
    assign m_axis_tuser  = r_out_dbl;

endmodule

FILE: src/bcc_checker.sv
// ----------------------------------------------------------------------------
// bcc_checker
// Port-level checks of the button click classifier, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bcc_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         psel,
    input logic                         penable,
    input logic                         pwrite,
    input logic [bcc_pkg::APB_AW-1:0]   paddr,
    input logic [bcc_pkg::APB_DW-1:0]   pwdata,
    input logic [bcc_pkg::APB_DW-1:0]   prdata,
    input logic                         pready,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [7:0]                   m_axis_tdata
);
    import bcc_pkg::*;

    // No event survives a reset.
    `BCC_ASSERT_ALWAYS(a_out_clear_after_rst, i_clk, !i_rst_n |=> !m_axis_tvalid, "event valid after reset")

    // A stalled event stays offered.
    `BCC_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "event dropped while stalled")

    // Events only name buttons that exist, and the padding bits stay zero.
    `BCC_ASSERT(a_index_range, i_clk, i_rst_n, m_axis_tvalid |-> (m_axis_tdata < 8'(NUM_BUTTONS)), "button index out of range")

    // A threshold write is read back on the next cycle.
    `BCC_ASSERT(a_thr_readback, i_clk, i_rst_n, $past(i_rst_n) && $past(psel && penable && pwrite && pready && (paddr == ADDR_HOLD_THR)) && (paddr == ADDR_HOLD_THR) |-> (prdata[THR_W-1:0] == $past(pwdata[THR_W-1:0])), "threshold readback mismatch")

endmodule

bind button_click_classifier_unit bcc_checker u_bcc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
